// File: sv/indexed_list_store_macros.svh
// Assertion macros shared by the indexed list store checkers.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define ILS_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define ILS_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ils_pkg.sv
// Package for the indexed list store: widths, codes and shared types.
`default_nettype none

package ils_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int MODE_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int TOT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_HEAD   = 3'd1,
        MODE_TAIL   = 3'd2,
        MODE_BEFORE = 3'd3,
        MODE_DELETE = 3'd4
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast command to every cell of the row.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: sv/ils_if.sv
// Valid/ready channel interfaces for commands and responses.
`default_nettype none

interface ils_cmd_if import ils_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output mode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input mode, input position, input item_value,
                    output ready);
endinterface

interface ils_rsp_if import ils_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [TOT_W-1:0]        entry_total;

    modport source (output valid, output read_value, output status, output entry_total,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_total,
                    output ready);
endinterface

`default_nettype wire

// File: sv/ils_cell.sv
// One storage cell of the list row: holds an entry, shifts with its neighbors.
`default_nettype none

module ils_cell import ils_pkg::*; #(
    parameter int INDEX_W = $clog2(CAPACITY_DEF)
) (
    input  wire logic               i_clk,
    input  wire t_cell_cmd          i_cmd,
    input  wire logic [INDEX_W-1:0] i_pos,
    input  wire logic [INDEX_W-1:0] i_index,
    input  wire logic [VAL_W-1:0]   i_left,
    input  wire logic [VAL_W-1:0]   i_right,
    input  wire logic [VAL_W-1:0]   i_value,
    output logic      [VAL_W-1:0]   o_value,
    output logic      [VAL_W-1:0]   o_hit_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins && (i_index > i_pos)) begin
            n_value = i_left;           // make room: take lower neighbor
        end else if (i_cmd.ins && (i_index == i_pos)) begin
            n_value = i_value;
        end else if (i_cmd.del && (i_index >= i_pos)) begin
            n_value = i_right;          // close the gap: take upper neighbor
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_hit_value = (i_index == i_pos) ? r_value : '0;

endmodule

`default_nettype wire

// File: sv/indexed_list_store.sv
// Top level of the indexed list store: command decode, cell row, response register.
//
// Usage
//   i_cmd  : command channel (valid/ready). Each transfer carries mode, position
//            and item_value: read, insert at head, insert at tail, insert before
//            a position, or delete at a position.
//   o_rsp  : response channel (valid/ready). Exactly one response per command,
//            in order: read_value (all ones unless a read hits), status
//            (done / position out of range / store full) and entry_total.
//   Storage is a row of CAPACITY cells. An insert or delete shifts every cell
//   above the target by one place in the same clock.
//   Latency: the response is valid the cycle after the command transfer.
//   Throughput: one command per cycle while responses are taken; the cell row
//   shifting once per cycle sets that figure.
//   Stall: the response register holds a finished result; a new command is
//   taken when that register is empty or is being emptied in the same cycle.
//   Reset: synchronous, active low. The list becomes empty and no response is
//   pending. Cell contents are not cleared; only entries below the count are
//   ever read.
`default_nettype none

module indexed_list_store import ils_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ils_cmd_if.sink    i_cmd,
    ils_rsp_if.source  o_rsp
);

    localparam int IW  = $clog2(CAPACITY);           // cell index width
    localparam int CW  = $clog2(CAPACITY + 1);       // count width
    localparam int PCW = (CW > POS_W) ? CW : POS_W;  // common compare width
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // Control state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;

    // Response payload
    logic [VAL_W-1:0] r_read_value;
    t_status          r_status;
    logic [TOT_W-1:0] r_total;

    logic             w_accept;
    logic [PCW-1:0]   w_pos_ext;
    logic [PCW-1:0]   w_cnt_ext;
    logic             w_full;
    logic             w_ins;
    logic             w_del;
    logic             w_rd_hit;
    logic [IW-1:0]    w_sel_pos;
    t_status          w_status;
    t_cell_cmd        w_cell_cmd;
    logic [VAL_W-1:0] w_rd_or;
    logic [VAL_W-1:0] w_rd_value;

    logic [VAL_W-1:0] w_cell_val [CAPACITY];
    logic [VAL_W-1:0] w_hit_val  [CAPACITY];

    // Take a command when the response register is free or draining
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_pos_ext = PCW'(i_cmd.position);
    assign w_cnt_ext = PCW'(r_count);
    assign w_full    = (r_count == FULL_CNT);

    // Decode: resolve head/tail/before into one insert position and check bounds.
    // Range checks come before the full check for indexed inserts.
    always_comb begin
        w_ins     = 1'b0;
        w_del     = 1'b0;
        w_rd_hit  = 1'b0;
        w_status  = ST_DONE;
        w_sel_pos = w_pos_ext[IW-1:0];
        case (t_mode'(i_cmd.mode))
            MODE_READ: begin
                if (w_pos_ext < w_cnt_ext) begin
                    w_rd_hit = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            MODE_HEAD: begin
                w_sel_pos = '0;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_TAIL: begin
                // count is below CAPACITY when the insert goes ahead
                w_sel_pos = w_cnt_ext[IW-1:0];
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_BEFORE: begin
                if (w_pos_ext > w_cnt_ext) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (w_pos_ext < w_cnt_ext) begin
                    w_del = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            default: begin
                w_status = ST_RANGE;   // unused mode codes
            end
        endcase
    end

    assign w_cell_cmd.ins = w_accept && w_ins;
    assign w_cell_cmd.del = w_accept && w_del;

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_val[g];
        end else begin : g_inner_r
            assign w_right = w_cell_val[g+1];
        end

        ils_cell #(
            .INDEX_W (IW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cell_cmd),
            .i_pos       (w_sel_pos),
            .i_index     (IW'(g)),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_value     (i_cmd.item_value),
            .o_value     (w_cell_val[g]),
            .o_hit_value (w_hit_val[g])
        );
    end

    // Exactly one cell matches the position; merge the masked outputs
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_or = w_rd_or | w_hit_val[i];
        end
    end

    assign w_rd_value = w_rd_hit ? w_rd_or : '1;

    always_comb begin
        n_count = r_count;
        if (w_cell_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cell_cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= w_rd_value;
            r_status     <= w_status;
            r_total      <= TOT_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_total = r_total;

endmodule

`default_nettype wire

// File: sv/ils_checker.sv
// Port-level checker for the indexed list store, bound to the top level.
`default_nettype none

`include "indexed_list_store_macros.svh"

module ils_checker import ils_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic [VAL_W-1:0] i_read_value,
    input wire logic [ST_W-1:0]  i_status,
    input wire logic [TOT_W-1:0] i_entry_total
);

    // A full store reports exactly CAPACITY entries
    `ILS_ASSERT_NOW(a_full_total,
        i_rsp_valid && (i_status == ST_FULL),
        i_entry_total == TOT_W'(CAPACITY),
        "full status with wrong entry total")

    // Any failed command returns all ones
    `ILS_ASSERT_NOW(a_fail_value,
        i_rsp_valid && (i_status != ST_DONE),
        i_read_value == '1,
        "failed command returned a value")

    // Leaving reset, no response is pending
    `ILS_ASSERT_NOW(a_reset_idle, $rose(i_rst_n), !i_rsp_valid, "response pending after reset")

    // A stalled response holds
    `ILS_ASSERT_NEXT(a_rsp_hold,
        i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_read_value) && $stable(i_status) && $stable(i_entry_total),
        "stalled response changed")

endmodule

bind indexed_list_store ils_checker #(
    .CAPACITY (CAPACITY)
) u_ils_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_read_value  (o_rsp.read_value),
    .i_status      (o_rsp.status),
    .i_entry_total (o_rsp.entry_total)
);

`default_nettype wire

// File: tb/sv/indexed_list_store_test.sv
// Self-checking testbench for the indexed list store: directed table, random list traffic.
`default_nettype none

module indexed_list_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_WAIT     = 12;
    localparam int LONG_HOLD    = 150;
    localparam int SETTLE       = 4;
    localparam int TIMEOUT_NS   = 4_000_000;

    localparam logic signed [VAL_W-1:0] MISSING_VALUE = '1;
    localparam logic signed [VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7fff_ffff;

    // Mode codes the block does not define; they must leave the list alone.
    localparam logic [MODE_W-1:0] MODE_BAD_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD_C = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } list_cmd_t;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        t_status                 status;
        logic [TOT_W-1:0]        entry_total;
    } list_rsp_t;

    // Directed row: command plus, where obvious, the response typed in.
    typedef struct {
        list_cmd_t cmd;
        bit        typed;
        list_rsp_t want;
    } dir_row_t;

    typedef enum int {PACE_NONE, PACE_ANY, PACE_SPARSE} pace_t;
    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED_OPS} list_bias_t;

    logic clk = 1'b0;
    logic rst_n;

    ils_cmd_if cmd_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_store #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Shadow copy of the list, advanced at each command transfer.
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int                      list_len = 0;

    list_rsp_t pending_rsp [$];
    int        failures = 0;
    int        rsp_seen = 0;

    int    snd_run = 0;
    pace_t snd_pace = PACE_NONE;
    int    rcv_run = 0;
    pace_t rcv_pace = PACE_NONE;

    // Response counts at which the receiver goes quiet for a long stretch.
    int hold_marks [$] = '{200, 750};

    dir_row_t directed_rows [24] = '{
        // empty list: every lookup and removal misses
        '{'{MODE_READ,   5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        '{'{MODE_DELETE, 5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        '{'{MODE_BEFORE, 5'd1,  32'sh11},  1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        // undefined modes
        '{'{MODE_BAD_A,  5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        '{'{MODE_BAD_B,  5'd31, -32'sd1},  1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        '{'{MODE_BAD_C,  5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        // indexed insert at 0 lands at the head; deleting the single entry empties it
        '{'{MODE_BEFORE, 5'd0,  VAL_MAX},  1'b1, '{MISSING_VALUE, ST_DONE,  5'd1}},
        '{'{MODE_READ,   5'd0,  32'sd0},   1'b1, '{VAL_MAX,       ST_DONE,  5'd1}},
        '{'{MODE_DELETE, 5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_READ,   5'd0,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd0}},
        '{'{MODE_HEAD,   5'd31, VAL_MIN},  1'b1, '{MISSING_VALUE, ST_DONE,  5'd1}},
        '{'{MODE_TAIL,   5'd0,  -32'sd1},  1'b1, '{MISSING_VALUE, ST_DONE,  5'd2}},
        // indexed insert at the count appends
        '{'{MODE_BEFORE, 5'd2,  32'sh1234_5678}, 1'b1, '{MISSING_VALUE, ST_DONE, 5'd3}},
        '{'{MODE_BEFORE, 5'd1,  32'sd0},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_READ,   5'd0,  32'sd0},   1'b1, '{VAL_MIN,       ST_DONE,  5'd4}},
        '{'{MODE_READ,   5'd1,  32'sd0},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_READ,   5'd2,  32'sd0},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_READ,   5'd3,  32'sd0},   1'b1, '{32'sh1234_5678, ST_DONE, 5'd4}},
        '{'{MODE_READ,   5'd4,  32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd4}},
        '{'{MODE_DELETE, 5'd31, 32'sd0},   1'b1, '{MISSING_VALUE, ST_RANGE, 5'd4}},
        '{'{MODE_BEFORE, 5'd31, 32'sh5a5a}, 1'b1, '{MISSING_VALUE, ST_RANGE, 5'd4}},
        '{'{MODE_DELETE, 5'd3,  32'sd0},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_DELETE, 5'd0,  32'sd0},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}},
        '{'{MODE_HEAD,   5'd0,  32'sd1},   1'b0, '{MISSING_VALUE, ST_DONE,  5'd0}}
    };

    function automatic void shift_in(int at, logic signed [VAL_W-1:0] v);
        for (int i = list_len; i > at; i--)
            list_vals[i] = list_vals[i-1];
        list_vals[at] = v;
        list_len++;
    endfunction

    // Applies one command to the shadow list and returns the response it must give.
    function automatic list_rsp_t predict_list_op(list_cmd_t c);
        list_rsp_t r;
        r.read_value = MISSING_VALUE;
        r.status     = ST_DONE;
        case (c.mode)
            MODE_READ: begin
                if (c.position < list_len)
                    r.read_value = list_vals[c.position];
                else
                    r.status = ST_RANGE;
            end
            MODE_HEAD, MODE_TAIL: begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    shift_in((c.mode == MODE_HEAD) ? 0 : list_len, c.item_value);
            end
            MODE_BEFORE: begin
                // range is judged before fullness
                if (c.position > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    shift_in(c.position, c.item_value);
            end
            MODE_DELETE: begin
                if (c.position < list_len) begin
                    for (int i = c.position; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.entry_total = TOT_W'(list_len);
        return r;
    endfunction

    // Idle cycles before the next item; the pace is redrawn after every 10 to 80 items.
    function automatic int draw_wait(inout int run_left, inout pace_t pace);
        if (run_left == 0) begin
            pace     = pace_t'($urandom_range(PACE_NONE, PACE_SPARSE));
            run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (pace)
            PACE_NONE: return 0;
            PACE_ANY:  return $urandom_range(0, MAX_WAIT);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    // Positions mostly near the live range so hits, appends and misses all occur.
    function automatic list_cmd_t make_random_cmd(list_bias_t bias);
        list_cmd_t c;
        int        ins_pct;
        int        del_pct;
        int        pick;
        case (bias)
            FILL_UP:    begin ins_pct = 65; del_pct = 10; end
            DRAIN_DOWN: begin ins_pct = 20; del_pct = 50; end
            default:    begin ins_pct = 40; del_pct = 25; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4)
            c.mode = MODE_W'($urandom_range(MODE_BAD_A, MODE_BAD_C));
        else if (pick < 4 + ins_pct)
            c.mode = MODE_W'($urandom_range(MODE_HEAD, MODE_BEFORE));
        else if (pick < 4 + ins_pct + del_pct)
            c.mode = MODE_DELETE;
        else
            c.mode = MODE_READ;
        if ($urandom_range(0, 4) == 0)
            c.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        else
            c.position = POS_W'($urandom_range(0, list_len));
        case ($urandom_range(0, 15))
            0:       c.item_value = VAL_MIN;
            1:       c.item_value = VAL_MAX;
            2:       c.item_value = '0;
            3:       c.item_value = MISSING_VALUE;
            default: c.item_value = $urandom();
        endcase
        return c;
    endfunction

    // Offers one command and records what it must produce once it transfers.
    task automatic offer_cmd(input list_cmd_t c, input bit typed, input list_rsp_t typed_rsp);
        int        gap;
        list_rsp_t predicted;
        gap = draw_wait(snd_run, snd_pace);
        @(negedge clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= c.mode;
        cmd_ch.position   <= c.position;
        cmd_ch.item_value <= c.item_value;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        predicted = predict_list_op(c);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    // Command side: reset, directed table, then biased random phases.
    initial begin : drive_cmds
        int         phase_left;
        list_bias_t bias;
        list_rsp_t  unused_rsp;
        phase_left        = 0;
        bias              = MIXED_OPS;
        unused_rsp        = '{MISSING_VALUE, ST_DONE, '0};
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = MODE_READ;
        cmd_ch.position   = '0;
        cmd_ch.item_value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);
        pause_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                bias       = list_bias_t'($urandom_range(FILL_UP, MIXED_OPS));
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if (n == RANDOM_ITEMS / 2)
                pause_until_drained();
            offer_cmd(make_random_cmd(bias), 1'b0, unused_rsp);
        end
        pause_until_drained();

        repeat (SETTLE) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Response side: random stalls, plus long holds that back up the command channel.
    initial begin : take_rsps
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = draw_wait(rcv_run, rcv_pace);
            if (hold_marks.size() != 0 && rsp_seen >= hold_marks[0]) begin
                void'(hold_marks.pop_front());
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin : check_rsps
        list_rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                $error("response transfer with no command outstanding");
                failures++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           rsp_ch.read_value);
                    failures++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    failures++;
                end
                if (rsp_ch.entry_total !== want.entry_total) begin
                    $error("entry_total: expected %0d, got %0d", want.entry_total,
                           rsp_ch.entry_total);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
